[rtl/olq_pkg.sv]
// Shared types and constants for the ordered list queue engine.
// Holds the command, status and state machine codes and the fixed field widths.
// No dependencies.
package olq_pkg;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int DATA_W  = 31;
   localparam int INDEX_W = 6;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_GET    = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_NEG  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

[rtl/ordered_list_queue_engine.sv]
// Ordered list and queue engine: a ring of entries in one synchronous memory.
// Push, pop, get, clear and a rejected or empty-list insert go from idle straight to the
// finish state, where the result is registered; other inserts and erases first scan the
// entries, one memory read and one write per cycle. The next item
// is accepted in the cycle after the result is registered, even if that result is still
// stalled. Reset empties the list; memory contents are kept. Depends on olq_pkg.
module ordered_list_queue_engine #(
   parameter int CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [olq_pkg::CMD_W-1:0]            req_command,
   input  logic signed [olq_pkg::VALUE_W-1:0]   req_value,
   input  logic [olq_pkg::INDEX_W-1:0]          req_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [olq_pkg::STAT_W-1:0]           rsp_status,
   output logic [olq_pkg::DATA_W-1:0]           rsp_data,
   output logic [olq_pkg::COUNT_W-1:0]          rsp_count
);
   import olq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [DATA_W-1:0] entry_mem [CAPACITY];

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic               neg_ff, neg_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic [CW-1:0]      cur_ff, cur_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic               found_ff, found_in;
   logic               removed_ff, removed_in;
   logic [DATA_W-1:0]  carry_ff, carry_in;
   logic [DATA_W-1:0]  rdata_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic               full, load, hit;
   logic [XW-1:0]      idx_x, cnt_x;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(pos);
      if (sum >= (CW+1)'(CAPACITY)) begin
         sum = sum - (CW+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   assign full  = (count_ff == CW'(CAPACITY));
   assign idx_x = XW'(req_index);
   assign cnt_x = XW'(count_ff);
   assign load  = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      neg_in        = neg_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      kept_in       = kept_ff;
      found_in      = found_ff;
      removed_in    = removed_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      hit           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_command;
               val_in     = req_value[DATA_W-1:0];
               neg_in     = req_value[VALUE_W-1];
               carry_in   = req_value[DATA_W-1:0];
               issue_in   = '0;
               pend_in    = 1'b0;
               kept_in    = '0;
               found_in   = 1'b0;
               removed_in = 1'b0;
               state_in   = S_FINISH;
               case (req_command)
                  CMD_INSERT: begin
                     if (!req_value[VALUE_W-1] && !full && count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_ERASE: begin
                     state_in = S_SCAN;
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        found_in  = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                     end
                  end
                  CMD_GET: begin
                     if (idx_x < cnt_x) begin
                        found_in  = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = slot_of(head_ff, idx_x[CW-1:0]);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (issue_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = slot_of(head_ff, issue_ff);
               issue_in  = issue_ff + CW'(1);
               cur_in    = issue_ff;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (cmd_ff == CMD_ERASE) begin
                  if (neg_ff || rdata_ff != val_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_of(head_ff, kept_ff);
                     mem_wdata = rdata_ff;
                     kept_in   = kept_ff + CW'(1);
                  end else begin
                     removed_in = 1'b1;
                  end
               end else begin
                  if (cur_ff == '0) begin
                     hit = val_ff > rdata_ff;
                  end else begin
                     hit = found_ff || (rdata_ff <= val_ff);
                  end
                  if (hit) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_of(head_ff, cur_ff);
                     mem_wdata = carry_ff;
                     carry_in  = rdata_ff;
                     found_in  = 1'b1;
                  end
               end
            end
            if (!pend_ff && issue_ff == count_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISS;
               rsp_data_in   = '0;
               case (cmd_ff)
                  CMD_PUSH, CMD_INSERT: begin
                     if (neg_ff) begin
                        rsp_status_in = ST_NEG;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_DONE;
                        mem_we        = 1'b1;
                        mem_waddr     = slot_of(head_ff, count_ff);
                        mem_wdata     = carry_ff;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  CMD_POP: begin
                     if (found_ff) begin
                        rsp_status_in = ST_DONE;
                        rsp_data_in   = rdata_ff;
                        count_in      = count_ff - CW'(1);
                        head_in       = (head_ff == AW'(CAPACITY - 1)) ? '0
                                                                        : head_ff + AW'(1);
                     end
                  end
                  CMD_ERASE: begin
                     count_in = kept_ff;
                     if (removed_ff) begin
                        rsp_status_in = ST_DONE;
                     end
                  end
                  CMD_GET: begin
                     if (found_ff) begin
                        rsp_status_in = ST_DONE;
                        rsp_data_in   = rdata_ff;
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_status_in = ST_DONE;
                     count_in      = '0;
                     head_in       = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= entry_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      neg_ff        <= neg_in;
      issue_ff      <= issue_in;
      cur_ff        <= cur_in;
      kept_ff       <= kept_in;
      found_ff      <= found_in;
      removed_ff    <= removed_in;
      carry_ff      <= carry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

[tb/olq_checker.sv]
// Checker for the ordered list queue engine: watches both channels, keeps its own
// ring of entries to predict every result, and compares results field by field.
// Depends on olq_pkg.
module olq_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [olq_pkg::CMD_W-1:0]            req_command,
   input  logic signed [olq_pkg::VALUE_W-1:0]   req_value,
   input  logic [olq_pkg::INDEX_W-1:0]          req_index,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [olq_pkg::STAT_W-1:0]           rsp_status,
   input  logic [olq_pkg::DATA_W-1:0]           rsp_data,
   input  logic [olq_pkg::COUNT_W-1:0]          rsp_count,
   output int                                   fail_count,
   output int                                   pending
);
   import olq_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   outcome_type       expected_q [$];
   logic [DATA_W-1:0] entries [CAPACITY];
   int                head_slot = 0;
   int                held = 0;

   initial begin
      fail_count = 0;
      pending = 0;
      for (int k = 0; k < CAPACITY; k++) begin
         entries[k] = '0;
      end
   end

   function automatic logic [DATA_W-1:0] ring_read(input int pos);
      return entries[(head_slot + pos) % CAPACITY];
   endfunction

   function automatic void ring_write(input int pos, input logic [DATA_W-1:0] v);
      entries[(head_slot + pos) % CAPACITY] = v;
   endfunction

   task automatic predict_outcome(input logic [CMD_W-1:0] cmd,
                                  input logic signed [VALUE_W-1:0] value,
                                  input logic [INDEX_W-1:0] index,
                                  output outcome_type r);
      logic              negative;
      logic [DATA_W-1:0] mag;
      logic [DATA_W-1:0] e;
      logic              hit;
      int                pos;
      int                kept;
      negative = value[VALUE_W-1];
      mag = value[DATA_W-1:0];
      r.status = ST_MISS;
      r.data = '0;
      case (cmd)
         CMD_PUSH, CMD_INSERT: begin
            if (negative) begin
               r.status = ST_NEG;
            end else if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               pos = held;
               if (cmd == CMD_INSERT && held > 0) begin
                  if (mag > ring_read(0)) begin
                     pos = 0;
                  end else begin
                     pos = 1;
                     while (pos < held && ring_read(pos) > mag) pos++;
                  end
               end
               for (int k = held; k > pos; k--) begin
                  ring_write(k, ring_read(k - 1));
               end
               ring_write(pos, mag);
               held++;
               r.status = ST_DONE;
            end
         end
         CMD_POP: begin
            if (held > 0) begin
               r.data = ring_read(0);
               head_slot = (head_slot + 1) % CAPACITY;
               held--;
               r.status = ST_DONE;
            end
         end
         CMD_ERASE: begin
            kept = 0;
            hit = 1'b0;
            for (int k = 0; k < held; k++) begin
               e = ring_read(k);
               if (!negative && e == mag) begin
                  hit = 1'b1;
               end else begin
                  ring_write(kept, e);
                  kept++;
               end
            end
            held = kept;
            r.status = hit ? ST_DONE : ST_MISS;
         end
         CMD_GET: begin
            if (int'(index) < held) begin
               r.data = ring_read(int'(index));
               r.status = ST_DONE;
            end
         end
         CMD_CLEAR: begin
            held = 0;
            head_slot = 0;
            r.status = ST_DONE;
         end
         default: begin
         end
      endcase
      r.count = held[COUNT_W-1:0];
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result with no item outstanding: status %0d data %0d count %0d",
                      rsp_status, rsp_data, rsp_count);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_data !== want.data) begin
                  $error("data mismatch: expected %0d, actual %0d", want.data, rsp_data);
                  fail_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count mismatch: expected %0d, actual %0d", want.count, rsp_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_outcome(req_command, req_value, req_index, want);
            expected_q.push_back(want);
         end
         pending <= expected_q.size();
      end
   end

endmodule

[tb/tb_ordered_list_queue_engine.sv]
// Top of the ordered list queue engine testbench: clock, reset, directed and random
// items in bursts, a stalling receiver with long holds, a watchdog and the verdict.
// Depends on olq_pkg, ordered_list_queue_engine and olq_checker.
module tb_ordered_list_queue_engine;
   import olq_pkg::*;

   localparam int CAPACITY = 64;
   localparam int IDLE_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int HOLD_CYCLES = 400;
   localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_command = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STAT_W-1:0]         rsp_status;
   logic [DATA_W-1:0]         rsp_data;
   logic [COUNT_W-1:0]        rsp_count;

   int fail_count;
   int pending;
   int results_seen = 0;
   int full_seen = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int cmd_sent [8] = '{default: 0};

   always #5 clock = ~clock;

   ordered_list_queue_engine #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_value(req_value), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_data(rsp_data), .rsp_count(rsp_count)
   );

   olq_checker #(.CAPACITY(CAPACITY)) CHECK (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_value(req_value), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_data(rsp_data), .rsp_count(rsp_count),
      .fail_count(fail_count), .pending(pending)
   );

   task automatic offer(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                        input logic [INDEX_W-1:0] i);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= c;
      req_value <= v;
      req_index <= i;
      do @(posedge clock); while (req_stall);
      cmd_sent[c]++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 15);
         6: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         7: return {1'b1, 31'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      return INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63));
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input mix_mode_type mode);
      int r;
      logic [CMD_W-1:0] undef;
      r = $urandom_range(0, 99);
      undef = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
      case (mode)
         MODE_FILL: begin
            if (r < 42) return CMD_PUSH;
            if (r < 80) return CMD_INSERT;
            if (r < 91) return CMD_GET;
            if (r < 94) return CMD_ERASE;
            if (r < 97) return CMD_POP;
            if (r < 98) return CMD_CLEAR;
            return undef;
         end
         MODE_DRAIN: begin
            if (r < 35) return CMD_POP;
            if (r < 60) return CMD_ERASE;
            if (r < 80) return CMD_GET;
            if (r < 88) return CMD_PUSH;
            if (r < 94) return CMD_INSERT;
            if (r < 97) return CMD_CLEAR;
            return undef;
         end
         default: begin
            if (r < 18) return CMD_PUSH;
            if (r < 36) return CMD_INSERT;
            if (r < 52) return CMD_POP;
            if (r < 66) return CMD_ERASE;
            if (r < 84) return CMD_GET;
            if (r < 90) return CMD_CLEAR;
            return undef;
         end
      endcase
   endfunction

   initial begin
      int           sent_random;
      int           seg_len;
      int           segment;
      mix_mode_type mode;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      offer(CMD_CLEAR, 0, 0);
      offer(CMD_POP, 0, 0);
      offer(CMD_GET, 0, 0);
      offer(CMD_ERASE, 5, 0);
      offer(CMD_PUSH, 0, 0);
      offer(CMD_PUSH, 32'sh7FFF_FFFF, 0);
      offer(CMD_PUSH, -1, 0);
      offer(CMD_INSERT, 32'sh8000_0000, 0);
      offer(CMD_INSERT, 32'sh7FFF_FFFF, 0);
      offer(CMD_INSERT, 5, 0);
      offer(CMD_INSERT, 5, 0);
      offer(CMD_INSERT, 32'sh7FFF_FFFF, 0);
      offer(CMD_GET, 0, 0);
      offer(CMD_GET, 0, 63);
      offer(CMD_GET, 0, 2);
      offer(CMD_ERASE, 5, 0);
      offer(CMD_ERASE, 5, 0);
      offer(CMD_ERASE, -5, 0);
      offer(CMD_ERASE, 32'sh7FFF_FFFF, 0);
      offer(CMD_POP, 0, 0);
      offer(CMD_UNDEF_LO, 3, 1);
      offer(CMD_UNDEF_HI, 3, 1);
      offer(CMD_PUSH, 3, 0);
      offer(CMD_CLEAR, 0, 0);
      offer(CMD_GET, 0, 0);
      drain_all();

      sent_random = 0;
      segment = 0;
      while (sent_random < RANDOM_ITEMS) begin
         if (segment == 0) begin
            mode = MODE_FILL;
            seg_len = 110;
         end else begin
            mode = mix_mode_type'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 140);
         end
         repeat (seg_len) begin
            offer(pick_command(mode), pick_value(), pick_index());
            sent_random++;
         end
         if ($urandom_range(0, 4) == 0) drain_all();
         segment++;
      end
      drain_all();
      repeat (10) @(posedge clock);

      $display("covered %0d items: push %0d, pop %0d, insert %0d, erase %0d, get %0d, clear %0d,",
               results_seen, cmd_sent[CMD_PUSH], cmd_sent[CMD_POP], cmd_sent[CMD_INSERT],
               cmd_sent[CMD_ERASE], cmd_sent[CMD_GET], cmd_sent[CMD_CLEAR]);
      $display("undefined %0d; %0d results reported the store full",
               cmd_sent[CMD_UNDEF_LO] + cmd_sent[CMD_UNDEF_HI], full_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("ordered_list_queue_engine regression: pass");
      end else begin
         $display("ordered_list_queue_engine regression: fail");
      end
      $finish;
   end

   initial begin
      stall_pattern_type pattern;
      int                pattern_left;
      int                hold_left;
      bit                early_hold_done;
      bit                late_hold_done;
      pattern = STALL_NONE;
      pattern_left = 0;
      hold_left = 0;
      early_hold_done = 1'b0;
      late_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && !early_hold_done && results_seen >= 150) begin
            hold_left = HOLD_CYCLES;
            early_hold_done = 1'b1;
         end
         if (hold_left == 0 && !late_hold_done && results_seen >= 700) begin
            hold_left = HOLD_CYCLES;
            late_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern = stall_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(30, 200);
            end
            pattern_left--;
            case (pattern)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 2) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (rsp_status == ST_FULL) full_seen <= full_seen + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ordered_list_queue_engine regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
